[rtl/wcel_pkg.sv]
// Shared constants and types of the weighted cross-entropy loss core.
`default_nettype none

package wcel_pkg;

  // Class and sample limits
  localparam int NUM_CLASSES = 4;
  localparam int NUM_WEIGHTS = 4;
  localparam logic [15:0] MAX_SAMPLES = 16'd65535;

  // Fixed-point constants
  localparam logic [16:0] ONE_Q16      = 17'd65536;
  localparam logic [20:0] NEG_LN_ZERO  = 21'd1310720;
  localparam logic [31:0] LN2_Q32      = 32'd2977044472;
  localparam logic [26:0] MEAN_MAX     = 27'd83886080;
  localparam logic [47:0] ACC_MAX      = 48'hFFFF_FFFF_FFFF;
  localparam logic [15:0] ALPHA_RESET  = 16'd0;
  localparam logic [15:0] WEIGHT_RESET = 16'd4096;

  // Iteration counts
  localparam int SQ_STEPS  = 16;
  localparam int DIV_STEPS = 48;

  // Configuration register indexes
  localparam logic [2:0] REG_ALPHA = 3'd0;
  localparam logic [2:0] REG_CW0   = 3'd1;
  localparam logic [2:0] REG_CW1   = 3'd2;
  localparam logic [2:0] REG_CW2   = 3'd3;
  localparam logic [2:0] REG_CW3   = 3'd4;

  // Divider control and status
  typedef struct packed {
    logic start;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

[rtl/weighted_cross_entropy_loss_core.sv]
// An item adding nothing stays in S_IDLE; p = 0 runs S_TW, S_PZ, S_TERM, S_ACC; any other runs
// S_TW, S_SQ, S_LN, S_NL, S_TERM, S_ACC, its cost set by the 16 squaring steps of -log2 on the
// shared multiplier. A last-of-batch item adds a serial division before the result.
// Items are taken one at a time; a result held in the output register stalls the core only
// when the next batch result is ready. Reset (rst_n low, synchronous) clears the loss sum,
// sample count and output valid, and loads alpha = 1.0 and all class weights = 1.0.
`default_nettype none

module weighted_cross_entropy_loss_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Configuration write port
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [16:0] cfg_wdata,
  // Input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,  // class_index[1:0], probability[18:2], last_of_sample[19]
  input  wire logic        in_tuser,  // is_true_class[0]
  input  wire logic        in_tlast,  // last_of_batch
  // Result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [47:0] out_tdata  // mean_loss[26:0], sample_count[42:27]
);

  typedef enum logic [3:0] {
    S_IDLE, S_TW, S_PZ, S_SQ, S_LN, S_NL, S_TERM, S_ACC, S_DIVGO, S_DIV, S_OUT
  } state_t;

  state_t      state_r;
  logic [4:0]  cnt_r;
  logic [16:0] alpha_r;
  logic [15:0] cw_r [wcel_pkg::NUM_WEIGHTS];
  logic [16:0] target_r;
  logic [15:0] weight_r;
  logic        pzero_r;
  logic        last_batch_r;
  logic [30:0] y_r;
  logic [3:0]  k_r;
  logic [15:0] frac_r;
  logic [31:0] tw_r;
  logic [20:0] nl_r;
  logic [47:0] acc_r;
  logic [15:0] samples_r;
  logic [15:0] sc_r;
  logic        out_valid_r;
  logic [26:0] out_mean_r;
  logic [15:0] out_count_r;

  logic [1:0]  in_cls;
  logic [16:0] in_prob;
  logic        in_last_sample;
  logic [16:0] p_sat;
  logic [16:0] a_sat;
  logic [16:0] target_c;
  logic        use_c;
  logic [3:0]  k_norm;
  logic [15:0] m_norm;

  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] mul_p;
  logic        sq_bit;
  logic [30:0] sq_y;
  logic [30:0] sq_src;
  logic [20:0] neglog2;
  logic [48:0] acc_sum;
  logic [47:0] acc_nxt;

  wcel_pkg::div_ctl_t  div_ctl;
  wcel_pkg::div_stat_t div_stat;
  logic [47:0]         quotient;
  logic [26:0]         mean_sat;
  logic                out_free;
  logic                load_out;

  // Unpack the input beat and form the target weight
  always_comb begin
    in_cls         = in_tdata[1:0];
    in_prob        = in_tdata[18:2];
    in_last_sample = in_tdata[19];
    p_sat    = (in_prob > wcel_pkg::ONE_Q16) ? wcel_pkg::ONE_Q16 : in_prob;
    a_sat    = (alpha_r > wcel_pkg::ONE_Q16) ? wcel_pkg::ONE_Q16 : alpha_r;
    target_c = in_tuser ? a_sat : (wcel_pkg::ONE_Q16 - a_sat);
    use_c    = (int'(in_cls) < wcel_pkg::NUM_CLASSES) && (target_c != 17'd0) &&
               (p_sat != wcel_pkg::ONE_Q16);
  end

  // Normalize the probability so its top bit is set
  always_comb begin
    k_norm = 4'd0;
    for (int i = 0; i < 16; i++) begin
      if (p_sat[i]) k_norm = 4'(15 - i);
    end
    m_norm = p_sat[15:0] << k_norm;
  end

  // Squaring step: take the next fraction bit of log2 from the product
  always_comb begin
    sq_bit  = mul_p[61];
    sq_y    = sq_bit ? mul_p[61:31] : mul_p[60:30];
    sq_src  = (cnt_r == 5'd0) ? y_r : sq_y;
    neglog2 = {({1'b0, k_r} + 5'd1), 16'd0} - {5'd0, frac_r};
  end

  // Select multiplier operands by step
  always_comb begin
    unique case (state_r)
      S_TW: begin
        mul_a = {15'd0, target_r};
        mul_b = {16'd0, weight_r};
      end
      S_SQ: begin
        mul_a = {1'b0, sq_src};
        mul_b = {1'b0, sq_src};
      end
      S_LN: begin
        mul_a = {11'd0, neglog2};
        mul_b = wcel_pkg::LN2_Q32;
      end
      S_TERM: begin
        mul_a = tw_r;
        mul_b = {11'd0, nl_r};
      end
      default: begin
        mul_a = 32'd0;
        mul_b = 32'd0;
      end
    endcase
  end

  wcel_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p_r (mul_p)
  );

  // Round the term and add it with saturation in one adder
  always_comb begin
    acc_sum = {1'b0, acc_r} + {24'd0, mul_p[52:28]} + {48'd0, mul_p[27]};
    acc_nxt = acc_sum[48] ? wcel_pkg::ACC_MAX : acc_sum[47:0];
  end

  assign div_ctl.start = (state_r == S_DIVGO);

  wcel_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (div_ctl),
    .dividend (acc_r),
    .divisor  (samples_r),
    .stat     (div_stat),
    .quotient (quotient)
  );

  // Clamp the mean, check room in the output register and decide when to load it
  always_comb begin
    mean_sat = (quotient > {21'd0, wcel_pkg::MEAN_MAX}) ? wcel_pkg::MEAN_MAX : quotient[26:0];
    out_free = !out_valid_r || out_tready;
    load_out = out_free && ((state_r == S_OUT) || ((state_r == S_DIV) && div_stat.done));
  end

  // Sequencer, configuration registers and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      acc_r       <= 48'd0;
      samples_r   <= 16'd0;
      alpha_r     <= {1'b1, wcel_pkg::ALPHA_RESET};
      for (int i = 0; i < wcel_pkg::NUM_WEIGHTS; i++) begin
        cw_r[i] <= wcel_pkg::WEIGHT_RESET;
      end
    end else begin
      // Write configuration
      if (cfg_we) begin
        unique case (cfg_index)
          wcel_pkg::REG_ALPHA: alpha_r <= cfg_wdata;
          wcel_pkg::REG_CW0:   cw_r[0] <= cfg_wdata[15:0];
          wcel_pkg::REG_CW1:   cw_r[1] <= cfg_wdata[15:0];
          wcel_pkg::REG_CW2:   cw_r[2] <= cfg_wdata[15:0];
          wcel_pkg::REG_CW3:   cw_r[3] <= cfg_wdata[15:0];
          default: ;
        endcase
      end

      // Load a new result, or drop the one taken
      if (load_out)                        out_valid_r <= 1'b1;
      else if (out_valid_r && out_tready)  out_valid_r <= 1'b0;

      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            target_r     <= target_c;
            weight_r     <= cw_r[in_cls];
            pzero_r      <= (p_sat == 17'd0);
            y_r          <= {m_norm, 15'd0};
            k_r          <= k_norm;
            last_batch_r <= in_tlast;
            cnt_r        <= 5'd0;
            if (in_last_sample && (samples_r != wcel_pkg::MAX_SAMPLES)) begin
              samples_r <= samples_r + 16'd1;
            end
            if (use_c)         state_r <= S_TW;
            else if (in_tlast) state_r <= S_DIVGO;
          end
        end
        S_TW: begin
          state_r <= pzero_r ? S_PZ : S_SQ;
        end
        S_PZ: begin
          tw_r    <= mul_p[31:0];
          nl_r    <= wcel_pkg::NEG_LN_ZERO;
          state_r <= S_TERM;
        end
        S_SQ: begin
          if (cnt_r == 5'd0) tw_r <= mul_p[31:0];
          else               frac_r <= {frac_r[14:0], sq_bit};
          cnt_r <= cnt_r + 5'd1;
          if (cnt_r == 5'(wcel_pkg::SQ_STEPS)) state_r <= S_LN;
        end
        S_LN: begin
          state_r <= S_NL;
        end
        S_NL: begin
          nl_r    <= mul_p[52:32] + {20'd0, mul_p[31]};
          state_r <= S_TERM;
        end
        S_TERM: begin
          state_r <= S_ACC;
        end
        S_ACC: begin
          acc_r   <= acc_nxt;
          state_r <= last_batch_r ? S_DIVGO : S_IDLE;
        end
        S_DIVGO: begin
          sc_r      <= samples_r;
          acc_r     <= 48'd0;
          samples_r <= 16'd0;
          state_r   <= S_DIV;
        end
        S_DIV: begin
          if (div_stat.done) begin
            if (out_free) begin
              out_mean_r  <= mean_sat;
              out_count_r <= sc_r;
              state_r     <= S_IDLE;
            end else begin
              state_r <= S_OUT;
            end
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_mean_r  <= mean_sat;
            out_count_r <= sc_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_count_r, out_mean_r};

  // The log loop always starts from a normalized mantissa
  a_norm: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SQ && cnt_r == 5'd0) |-> y_r[30])
    else $error("log mantissa not normalized");

  // A delivered mean never exceeds the clamp
  a_mean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[26:0] <= wcel_pkg::MEAN_MAX))
    else $error("mean above clamp");

  // No item is taken while the divider runs
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.busy |-> !in_tready)
    else $error("input ready during division");

  // Batch state is cleared once the division has started
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (acc_r == 48'd0 && samples_r == 16'd0))
    else $error("batch state not cleared");

endmodule

`default_nettype wire

[rtl/wcel_mul.sv]
// Shared 32x32 multiplier with registered product.
`default_nettype none

module wcel_mul (
  input  wire logic        clk,
  input  wire logic [31:0] a,
  input  wire logic [31:0] b,
  output logic      [63:0] p_r
);

  // Register the product every cycle
  always_ff @(posedge clk) begin
    p_r <= {32'd0, a} * {32'd0, b};
  end

endmodule

`default_nettype wire

[rtl/wcel_div.sv]
// Restoring divider, one quotient bit per cycle, 48-bit dividend by 16-bit divisor.
`default_nettype none

module wcel_div (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire wcel_pkg::div_ctl_t   ctl,
  input  wire logic [47:0]          dividend,
  input  wire logic [15:0]          divisor,
  output wcel_pkg::div_stat_t       stat,
  output logic [47:0]               quotient
);

  logic [47:0] q_r;
  logic [15:0] rem_r;
  logic [15:0] d_r;
  logic [5:0]  cnt_r;
  logic        busy_r;
  logic        done_r;
  logic [16:0] rem_sh;
  logic        ge;
  logic [16:0] rem_nxt;

  // Shift in the next dividend bit and trial-subtract
  always_comb begin
    rem_sh  = {rem_r, q_r[47]};
    ge      = rem_sh >= {1'b0, d_r};
    rem_nxt = ge ? (rem_sh - {1'b0, d_r}) : rem_sh;
  end

  // Iterate over the dividend bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (ctl.start) begin
        q_r    <= dividend;
        d_r    <= (divisor == 16'd0) ? 16'd1 : divisor;
        rem_r  <= 16'd0;
        cnt_r  <= 6'd0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r <= rem_nxt[15:0];
        q_r   <= {q_r[46:0], ge};
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'(wcel_pkg::DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = q_r;

endmodule

`default_nettype wire

[bench/tb_weighted_cross_entropy_loss_core.sv]
// Self-checking bench of the weighted cross-entropy loss core: directed and random beats.
`timescale 1ns / 100ps

module tb_weighted_cross_entropy_loss_core;

  localparam int LATENCY_SLACK  = 100;   // item + division + output slack, in cycles
  localparam int WATCHDOG_LIMIT = 2000;  // cycles with no handshake before giving up
  localparam int RANDOM_ITEMS   = 1400;
  localparam int NUM_SETTINGS   = 6;

  typedef enum logic [2:0] {
    OP_BEAT,   // drive one input item
    OP_IDLE,   // hold the input side low for a number of cycles
    OP_DRAIN,  // wait until every result is back and the core is quiet
    OP_WRITE,  // one configuration write
    OP_CALM    // stop random receiver stalls from here on
  } op_kind_t;

  typedef struct {
    logic [1:0]  cls;
    logic        true_cls;
    logic [16:0] prob;
    logic        last_smp;
    logic        last_bat;
  } loss_item_t;

  typedef struct {
    logic [26:0] mean;
    logic [15:0] count;
  } loss_result_t;

  typedef struct {
    op_kind_t    kind;
    loss_item_t  item;
    int          cycles;
    logic [2:0]  reg_idx;
    logic [16:0] reg_val;
  } stim_op_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [16:0] cfg_wdata = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;   // class_index[1:0], probability[18:2], last_of_sample[19]
  logic        in_tuser = 1'b0; // is_true_class[0]
  logic        in_tlast = 1'b0; // last_of_batch
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;       // mean_loss[26:0], sample_count[42:27]

  weighted_cross_entropy_loss_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // Loss model state and configuration
  logic [16:0]  alpha_reg = wcel_pkg::ONE_Q16;
  logic [15:0]  weight_reg [wcel_pkg::NUM_WEIGHTS] = '{default: wcel_pkg::WEIGHT_RESET};
  logic [47:0]  loss_sum = '0;
  logic [15:0]  sample_tally = '0;

  stim_op_t     pending_ops [$];
  loss_result_t expected_means [$];
  loss_item_t   beat_on_bus;
  logic         calm = 1'b0;
  int           error_count = 0;
  int           beats_taken = 0;
  int           results_seen = 0;
  int           writes_done = 0;
  int           beats_queued = 0;

  // Clock
  initial begin
    forever #5 clk = ~clk;
  end

  // Reset, once
  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
  end

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    if (error_count < 100)
      $display("[%0t] MISMATCH %s: got %0d, expected %0d", $realtime, what, got, want);
    error_count++;
  endtask

  function automatic logic [16:0] clamp_q16(input logic [16:0] v);
    return (v > wcel_pkg::ONE_Q16) ? wcel_pkg::ONE_Q16 : v;
  endfunction

  // -ln(p) in Q.16 for p in 1..65535, by repeated squaring of the normalized mantissa
  function automatic logic [20:0] neg_ln_q16(input logic [16:0] p);
    logic [16:0] m;
    logic [63:0] y;
    logic [63:0] frac;
    logic [63:0] nlog2;
    int          k;
    m = p;
    k = 0;
    while (m < 17'd32768) begin
      m = m << 1;
      k++;
    end
    y = 64'(m) << 15;
    frac = '0;
    for (int i = 0; i < wcel_pkg::SQ_STEPS; i++) begin
      y = (y * y) >> 30;
      frac = frac << 1;
      if (y >= 64'h8000_0000) begin
        frac = frac | 64'd1;
        y = y >> 1;
      end
    end
    nlog2 = 64'(k + 1) * 64'd65536 - frac;
    return 21'((nlog2 * 64'(wcel_pkg::LN2_Q32) + 64'h8000_0000) >> 32);
  endfunction

  // Fold one item into the loss sum; return 1 with the batch mean on last_of_batch
  function automatic bit step_loss_model(input loss_item_t it, output loss_result_t res);
    logic [16:0] p;
    logic [16:0] a;
    logic [16:0] target;
    logic [63:0] nl;
    logic [63:0] term;
    logic [63:0] divisor;
    logic [63:0] mean;
    p = clamp_q16(it.prob);
    a = clamp_q16(alpha_reg);
    target = it.true_cls ? a : wcel_pkg::ONE_Q16 - a;
    res.mean = '0;
    res.count = '0;
    if (int'(it.cls) < wcel_pkg::NUM_CLASSES && target != 0 && p != wcel_pkg::ONE_Q16) begin
      nl = (p == 0) ? 64'(wcel_pkg::NEG_LN_ZERO) : 64'(neg_ln_q16(p));
      term = (64'(target) * nl * 64'(weight_reg[it.cls]) + 64'h800_0000) >> 28;
      if (64'(loss_sum) > 64'(wcel_pkg::ACC_MAX) - term) loss_sum = wcel_pkg::ACC_MAX;
      else loss_sum = loss_sum + 48'(term);
    end
    if (it.last_smp && sample_tally < wcel_pkg::MAX_SAMPLES) sample_tally++;
    if (!it.last_bat) return 1'b0;
    divisor = (sample_tally == 0) ? 64'd1 : 64'(sample_tally);
    mean = '0;
    if (loss_sum != 0) begin
      mean = 64'(loss_sum) / divisor;
      if (mean > 64'(wcel_pkg::MEAN_MAX)) mean = 64'(wcel_pkg::MEAN_MAX);
    end
    res.mean = 27'(mean);
    res.count = sample_tally;
    loss_sum = '0;
    sample_tally = '0;
    return 1'b1;
  endfunction

  function automatic void apply_write(input logic [2:0] idx, input logic [16:0] val);
    if (idx == wcel_pkg::REG_ALPHA) alpha_reg = val;
    else if (idx >= wcel_pkg::REG_CW0 && idx <= wcel_pkg::REG_CW3)
      weight_reg[2'(idx - wcel_pkg::REG_CW0)] = val[15:0];
  endfunction

  // Stimulus queue builders
  task automatic push_item(input logic [1:0] c, input logic t, input logic [16:0] p,
                           input logic ls, input logic lb);
    stim_op_t op;
    op.kind = OP_BEAT;
    op.item = '{cls: c, true_cls: t, prob: p, last_smp: ls, last_bat: lb};
    op.cycles = 0;
    op.reg_idx = '0;
    op.reg_val = '0;
    pending_ops.insert(pending_ops.size(), op);
    beats_queued++;
  endtask

  task automatic push_ctrl(input op_kind_t kind, input int cycles,
                           input logic [2:0] idx, input logic [16:0] val);
    stim_op_t op;
    op.kind = kind;
    op.item = '{cls: '0, true_cls: 1'b0, prob: '0, last_smp: 1'b0, last_bat: 1'b0};
    op.cycles = cycles;
    op.reg_idx = idx;
    op.reg_val = val;
    pending_ops.insert(pending_ops.size(), op);
  endtask

  function automatic logic [16:0] pick_prob();
    case ($urandom_range(0, 11))
      0:       return 17'd0;
      1:       return wcel_pkg::ONE_Q16;
      2:       return 17'($urandom_range(65537, 131071));
      3:       return 17'd1;
      4:       return 17'd65535;
      5:       return 17'($urandom_range(1, 255));
      default: return 17'($urandom_range(1, 65535));
    endcase
  endfunction

  function automatic logic [16:0] pick_alpha();
    case ($urandom_range(0, 5))
      0:       return 17'd0;
      1:       return wcel_pkg::ONE_Q16;
      2:       return 17'($urandom_range(65537, 131071));
      default: return 17'($urandom_range(0, 65536));
    endcase
  endfunction

  function automatic logic [16:0] pick_weight();
    case ($urandom_range(0, 5))
      0:       return 17'd0;
      1:       return 17'd65535;
      2:       return 17'($urandom_range(0, 8192));
      default: return 17'($urandom_range(0, 65535));
    endcase
  endfunction

  // Drain, then load a random setting; sometimes poke an unused register index
  task automatic push_setting();
    push_ctrl(OP_DRAIN, 0, '0, '0);
    push_ctrl(OP_WRITE, 0, wcel_pkg::REG_ALPHA, pick_alpha());
    push_ctrl(OP_WRITE, 0, wcel_pkg::REG_CW0, pick_weight());
    push_ctrl(OP_WRITE, 0, wcel_pkg::REG_CW1, pick_weight());
    push_ctrl(OP_WRITE, 0, wcel_pkg::REG_CW2, pick_weight());
    push_ctrl(OP_WRITE, 0, wcel_pkg::REG_CW3, pick_weight());
    if ($urandom_range(0, 1) == 0)
      push_ctrl(OP_WRITE, 0, 3'($urandom_range(wcel_pkg::REG_CW3 + 1, 7)), 17'($urandom));
  endtask

  // One well-formed batch of 1..5 samples, four classes each, one true class
  task automatic push_batch(input bit gappy);
    int nsamp;
    int true_c;
    nsamp = $urandom_range(1, 5);
    for (int s = 0; s < nsamp; s++) begin
      true_c = $urandom_range(0, 3);
      for (int c = 0; c < 4; c++) begin
        if (gappy && $urandom_range(0, 3) == 0)
          push_ctrl(OP_IDLE, $urandom_range(1, 16), '0, '0);
        push_item(2'(c), logic'(c == true_c), pick_prob(), logic'(c == 3),
                  logic'(c == 3 && s == nsamp - 1));
      end
    end
  endtask

  // Driver: one beat or control op at a time, in queue order
  always @(posedge clk) begin : driver
    logic         nvalid;
    logic         nwe;
    logic         took;
    loss_result_t res;
    int           idle_count;
    int           quiet_count;
    nvalid = in_tvalid;
    nwe = 1'b0;
    took = 1'b0;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        if (step_loss_model(beat_on_bus, res))
          expected_means.insert(expected_means.size(), res);
        beats_taken++;
        took = 1'b1;
        nvalid = 1'b0;
      end
      if (!nvalid && pending_ops.size() > 0) begin
        case (pending_ops[0].kind)
          OP_BEAT: begin
            beat_on_bus = pending_ops[0].item;
            in_tdata <= {4'b0, beat_on_bus.last_smp, beat_on_bus.prob, beat_on_bus.cls};
            in_tuser <= beat_on_bus.true_cls;
            in_tlast <= beat_on_bus.last_bat;
            nvalid = 1'b1;
            void'(pending_ops.pop_front());
          end
          OP_IDLE: begin
            idle_count++;
            if (idle_count >= pending_ops[0].cycles) begin
              idle_count = 0;
              void'(pending_ops.pop_front());
            end
          end
          OP_DRAIN: begin
            if (expected_means.size() == 0 && !took && !out_tvalid) quiet_count++;
            else quiet_count = 0;
            if (quiet_count >= LATENCY_SLACK) begin
              quiet_count = 0;
              void'(pending_ops.pop_front());
            end
          end
          OP_WRITE: begin
            nwe = 1'b1;
            cfg_index <= pending_ops[0].reg_idx;
            cfg_wdata <= pending_ops[0].reg_val;
            apply_write(pending_ops[0].reg_idx, pending_ops[0].reg_val);
            writes_done++;
            void'(pending_ops.pop_front());
          end
          OP_CALM: begin
            calm <= 1'b1;
            void'(pending_ops.pop_front());
          end
          default: void'(pending_ops.pop_front());
        endcase
      end
    end
    in_tvalid <= nvalid;
    cfg_we <= nwe;
  end

  // Monitor: check each result beat against the oldest expected batch mean
  always @(posedge clk) begin : monitor
    logic         nready;
    loss_result_t want;
    int           stall_left;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (expected_means.size() == 0) begin
        report_mismatch("result beat with no batch pending", out_tdata, 0);
      end else begin
        want = expected_means.pop_front();
        if (out_tdata[26:0] !== want.mean)
          report_mismatch("mean_loss", out_tdata[26:0], want.mean);
        if (out_tdata[42:27] !== want.count)
          report_mismatch("sample_count", out_tdata[42:27], want.count);
        if (out_tdata[47:43] !== 5'b0)
          report_mismatch("tdata padding", out_tdata[47:43], 0);
      end
    end
    // Random receiver stalls in bursts; none once calm
    if (calm || !rst_n) begin
      stall_left = 0;
      nready = 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      nready = 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 16) - 1;
      nready = 1'b0;
    end else begin
      nready = 1'b1;
    end
    out_tready <= nready;
  end

  // Watchdog: end the run when no handshake happens for too long
  always @(posedge clk) begin : watchdog
    int stuck;
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we)
      stuck = 0;
    else
      stuck++;
    if (stuck >= WATCHDOG_LIMIT) begin
      $display("[%0t] watchdog: no handshake for %0d cycles", $realtime, stuck);
      $display("** weighted_cross_entropy_loss_core: FAILED **");
      $finish;
    end
  end

  initial begin : stimulus
    int  rand_start;
    int  phase_end;
    int  noise;
    bit  gappy;
    bit  calm_pushed;

    // Reset settings: alpha 1.0, weights 1.0
    push_item(2'd0, 1'b1, 17'd0, 1'b0, 1'b0);       // log of zero
    push_item(2'd1, 1'b0, 17'd0, 1'b0, 1'b0);       // zero target
    push_item(2'd2, 1'b0, 17'd65535, 1'b0, 1'b0);
    push_item(2'd3, 1'b0, 17'd131071, 1'b1, 1'b0);
    push_item(2'd1, 1'b1, 17'd1, 1'b0, 1'b0);       // smallest nonzero p
    push_item(2'd2, 1'b1, 17'd65535, 1'b0, 1'b0);
    push_item(2'd3, 1'b1, wcel_pkg::ONE_Q16, 1'b0, 1'b0);  // p of one adds nothing
    push_item(2'd0, 1'b1, 17'd131071, 1'b0, 1'b0);  // p above one saturates
    push_item(2'd3, 1'b1, 17'd32768, 1'b1, 1'b1);   // both marks on one beat
    push_item(2'd0, 1'b0, wcel_pkg::ONE_Q16, 1'b0, 1'b1);  // empty batch, zero sum
    push_item(2'd2, 1'b1, 17'd12345, 1'b0, 1'b1);   // empty batch, nonzero sum

    // Alpha 0, heaviest weights: mean saturates
    push_ctrl(OP_DRAIN, 0, '0, '0);
    push_ctrl(OP_WRITE, 0, wcel_pkg::REG_ALPHA, 17'd0);
    push_ctrl(OP_WRITE, 0, wcel_pkg::REG_CW0, 17'd65535);
    push_ctrl(OP_WRITE, 0, wcel_pkg::REG_CW1, 17'd65535);
    push_ctrl(OP_WRITE, 0, wcel_pkg::REG_CW2, 17'd65535);
    push_ctrl(OP_WRITE, 0, wcel_pkg::REG_CW3, 17'd65535);
    push_ctrl(OP_WRITE, 0, 3'(wcel_pkg::REG_CW3 + 1), 17'h1FFFF);
    push_ctrl(OP_WRITE, 0, 3'd7, 17'h1FFFF);
    for (int c = 0; c < 4; c++) push_item(2'(c), 1'b0, 17'd0, 1'b0, 1'b0);
    push_item(2'd0, 1'b0, 17'd0, 1'b1, 1'b1);
    push_item(2'd1, 1'b1, 17'd0, 1'b1, 1'b1);

    // Alpha above one, zero weights
    push_ctrl(OP_DRAIN, 0, '0, '0);
    push_ctrl(OP_WRITE, 0, wcel_pkg::REG_ALPHA, 17'd131071);
    push_ctrl(OP_WRITE, 0, wcel_pkg::REG_CW0, 17'd0);
    push_ctrl(OP_WRITE, 0, wcel_pkg::REG_CW1, 17'd0);
    push_ctrl(OP_WRITE, 0, wcel_pkg::REG_CW2, 17'd0);
    push_ctrl(OP_WRITE, 0, wcel_pkg::REG_CW3, 17'd0);
    push_item(2'd2, 1'b1, 17'd0, 1'b1, 1'b1);

    // Label smoothing at one half, mixed weights
    push_ctrl(OP_DRAIN, 0, '0, '0);
    push_ctrl(OP_WRITE, 0, wcel_pkg::REG_ALPHA, 17'd32768);
    push_ctrl(OP_WRITE, 0, wcel_pkg::REG_CW0, 17'd4096);
    push_ctrl(OP_WRITE, 0, wcel_pkg::REG_CW1, 17'd1);
    push_ctrl(OP_WRITE, 0, wcel_pkg::REG_CW2, 17'd65535);
    push_ctrl(OP_WRITE, 0, wcel_pkg::REG_CW3, 17'd12288);
    push_item(2'd0, 1'b1, 17'd500, 1'b0, 1'b0);
    push_item(2'd1, 1'b0, 17'd20000, 1'b0, 1'b0);
    push_item(2'd2, 1'b0, 17'd1, 1'b0, 1'b0);
    push_item(2'd3, 1'b0, 17'd65535, 1'b1, 1'b1);

    // Random batches over several settings, with noise and mid-phase drains
    rand_start = beats_queued;
    calm_pushed = 1'b0;
    for (int ph = 0; ph < NUM_SETTINGS; ph++) begin
      push_setting();
      phase_end = rand_start + (RANDOM_ITEMS * (ph + 1)) / NUM_SETTINGS;
      while (beats_queued < phase_end) begin
        if (!calm_pushed && beats_queued >= rand_start + RANDOM_ITEMS - 150) begin
          push_ctrl(OP_CALM, 0, '0, '0);
          calm_pushed = 1'b1;
        end
        gappy = !calm_pushed && ($urandom_range(0, 2) != 0);
        if (!calm_pushed && $urandom_range(0, 9) == 0) push_ctrl(OP_DRAIN, 0, '0, '0);
        if ($urandom_range(0, 6) == 0) begin
          noise = $urandom_range(1, 3);
          for (int n = 0; n < noise; n++)
            push_item(2'($urandom), 1'($urandom), 17'($urandom_range(0, 131071)),
                      1'($urandom), logic'($urandom_range(0, 5) == 0));
        end else begin
          push_batch(gappy);
        end
      end
    end
    push_ctrl(OP_DRAIN, 0, '0, '0);

    // Wait for the queue to empty, then a quiet tail
    while (pending_ops.size() != 0 || in_tvalid) @(posedge clk);
    repeat (LATENCY_SLACK) @(posedge clk);
    if (expected_means.size() != 0)
      report_mismatch("batch results never delivered", 0, expected_means.size());

    $display("Run covered %0d input beats, %0d batch results and %0d register writes.",
             beats_taken, results_seen, writes_done);
    $display("Settings ranged over alpha 0..above 1.0 and weights 0..max, with stalls on both sides.");
    if (error_count == 0) begin
      $display("** weighted_cross_entropy_loss_core: PASSED **");
    end else begin
      $display("** weighted_cross_entropy_loss_core: FAILED **");
    end
    $finish;
  end

endmodule
